FILE: src/assert_macros.svh
// Assertion macros shared by the escape-time block.
// Depends on nothing; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/jet_pkg.sv
// Types, constants and saturation helpers for the escape-time block.
// Depends on nothing; used by the interfaces and every module.
package jet_pkg;

  localparam int PIX_W  = 12;  // pixel column and row
  localparam int CNT_W  = 11;  // iteration count
  localparam int W      = 48;  // working value, Q20.28
  localparam int OP_W   = W + 1; // product operand, wide enough for x+y
  localparam int CFG_W  = 32;
  localparam int CIDX_W = 4;
  localparam int QDEPTH = 2;

  localparam logic [CIDX_W-1:0] REG_C_REAL   = 4'd0;
  localparam logic [CIDX_W-1:0] REG_C_IMAG   = 4'd1;
  localparam logic [CIDX_W-1:0] REG_X_ORIGIN = 4'd2;
  localparam logic [CIDX_W-1:0] REG_Y_ORIGIN = 4'd3;
  localparam logic [CIDX_W-1:0] REG_X_STEP   = 4'd4;
  localparam logic [CIDX_W-1:0] REG_Y_STEP   = 4'd5;
  localparam logic [CIDX_W-1:0] REG_ITER_LIM = 4'd6;
  localparam logic [CIDX_W-1:0] REG_RADIUS   = 4'd7;

  localparam logic signed [31:0] RST_ORIGIN = -32'sd536870912;
  localparam logic [30:0]        RST_STEP   = 31'd1048576;
  localparam logic [9:0]         RST_LIMIT  = 10'd250;
  localparam logic [7:0]         RST_RADIUS = 8'd250;

  typedef struct packed {
    logic signed [31:0] c_real;
    logic signed [31:0] c_imag;
    logic signed [31:0] x_origin;
    logic signed [31:0] y_origin;
    logic [30:0]        x_step;
    logic [30:0]        y_step;
    logic [9:0]         iter_limit;
    logic [7:0]         esc_radius;
  } jet_cfg_t;

  // One queued pixel: echo fields plus its mapped start point.
  typedef struct packed {
    logic [PIX_W-1:0]    col;
    logic [PIX_W-1:0]    row;
    logic signed [W-1:0] x0;
    logic signed [W-1:0] y0;
  } jet_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } jet_q_stat_t;

  // Saturate a 50-bit signed sum to the working width.
  function automatic logic signed [W-1:0] sat_w(input logic signed [W+1:0] v);
    logic signed [W-1:0] r;
    if ((v[W+1] == v[W]) && (v[W] == v[W-1])) begin
      r = v[W-1:0];
    end else if (v[W+1]) begin
      r = {1'b1, {(W-1){1'b0}}};
    end else begin
      r = {1'b0, {(W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

FILE: src/jet_if.sv
// Handshake interfaces of the escape-time block: pixels in, results out,
// configuration writes. Depends on jet_pkg.
interface jet_pix_if;
  import jet_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_col;
  logic [PIX_W-1:0] pixel_row;
  modport source(output valid, pixel_col, pixel_row, input ready);
  modport sink(input valid, pixel_col, pixel_row, output ready);
endinterface

interface jet_res_if;
  import jet_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_col;
  logic [PIX_W-1:0] out_row;
  logic [CNT_W-1:0] iter_count;
  logic             escaped;
  modport source(output valid, out_col, out_row, iter_count, escaped, input ready);
  modport sink(input valid, out_col, out_row, iter_count, escaped, output ready);
endinterface

interface jet_cfg_if;
  import jet_pkg::*;
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] reg_index;
  logic [CFG_W-1:0]  wdata;
  modport source(output valid, reg_index, wdata, input ready);
  modport sink(input valid, reg_index, wdata, output ready);
endinterface

FILE: src/jet_front.sv
// Front end: accepts pixels, clamps them and maps them to start points.
// Depends on jet_pkg and jet_pix_if; feeds jet_queue.
module jet_front #(
  parameter int MAX_DIM = 4096
) (
  jet_pix_if.sink               in_pix,
  input  jet_pkg::jet_cfg_t     cfg,
  input  jet_pkg::jet_q_stat_t  qs,
  output logic                  push,
  output jet_pkg::jet_item_t    item
);
  import jet_pkg::*;

  logic [PIX_W-1:0] mc;
  logic [PIX_W-1:0] mr;
  logic [42:0]      px;
  logic [42:0]      py;

  assign in_pix.ready = !qs.full;
  assign push         = in_pix.valid && !qs.full;

  // Indices beyond the image are pinned to the last column or row.
  assign mc = (32'(in_pix.pixel_col) >= MAX_DIM) ? PIX_W'(MAX_DIM - 1) : in_pix.pixel_col;
  assign mr = (32'(in_pix.pixel_row) >= MAX_DIM) ? PIX_W'(MAX_DIM - 1) : in_pix.pixel_row;

  assign px = 43'(mc) * 43'(cfg.x_step);
  assign py = 43'(mr) * 43'(cfg.y_step);

  // The offset stays below 2^43 plus the origin, so no saturation occurs.
  always_comb begin
    item.col = in_pix.pixel_col;
    item.row = in_pix.pixel_row;
    item.x0  = {{(W-32){cfg.x_origin[31]}}, cfg.x_origin} + {{(W-43){1'b0}}, px};
    item.y0  = {{(W-32){cfg.y_origin[31]}}, cfg.y_origin} + {{(W-43){1'b0}}, py};
  end

endmodule

FILE: src/jet_queue.sv
// Short FIFO of mapped pixels between the front end and the iteration engine.
// Depends on jet_pkg.
module jet_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  jet_pkg::jet_item_t   push_item,
  input  logic                 pop,
  output jet_pkg::jet_item_t   pop_item,
  output jet_pkg::jet_q_stat_t qs
);
  import jet_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);

  jet_item_t        mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   count_r;

  assign qs.full   = (count_r == (PTR_W+1)'(QDEPTH));
  assign qs.empty  = (count_r == '0);
  assign pop_item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: src/jet_mul.sv
// Two-stage fixed-point product unit: Q.28 product of two signed operands,
// truncated toward zero and saturated to the working width. Depends on jet_pkg.
module jet_mul (
  input  logic                              clk,
  input  logic signed [jet_pkg::OP_W-1:0]   a,
  input  logic signed [jet_pkg::OP_W-1:0]   b,
  output logic signed [jet_pkg::W-1:0]      p
);
  import jet_pkg::*;

  localparam int HALF = (OP_W + 1) / 2;
  localparam int MW   = 2 * HALF;
  localparam int FW   = 2 * MW;
  localparam int QW   = FW - 28;

  logic [OP_W-1:0]  ma;
  logic [OP_W-1:0]  mb;
  logic [MW-1:0]    wa;
  logic [MW-1:0]    wb;
  logic [MW-1:0]    p00_r;
  logic [MW-1:0]    p01_r;
  logic [MW-1:0]    p10_r;
  logic [MW-1:0]    p11_r;
  logic             neg_r;
  logic [FW-1:0]    full;
  logic [QW-1:0]    q;
  logic [QW-1:0]    lim;
  logic [QW-1:0]    qs;
  logic signed [W-1:0] p_r;

  // Magnitudes in two's complement; the most negative value maps correctly
  // because the result is read as unsigned.
  assign ma = a[OP_W-1] ? (~a + 1'b1) : a;
  assign mb = b[OP_W-1] ? (~b + 1'b1) : b;
  assign wa = {{(MW-OP_W){1'b0}}, ma};
  assign wb = {{(MW-OP_W){1'b0}}, mb};

  always_ff @(posedge clk) begin
    p00_r <= wa[HALF-1:0]  * wb[HALF-1:0];
    p01_r <= wa[HALF-1:0]  * wb[MW-1:HALF];
    p10_r <= wa[MW-1:HALF] * wb[HALF-1:0];
    p11_r <= wa[MW-1:HALF] * wb[MW-1:HALF];
    neg_r <= a[OP_W-1] ^ b[OP_W-1];
  end

  always_comb begin
    full = {{MW{1'b0}}, p00_r}
         + (({{MW{1'b0}}, p01_r} + {{MW{1'b0}}, p10_r}) << HALF)
         + {p11_r, {MW{1'b0}}};
    q    = full[FW-1:28];
    lim  = neg_r ? (QW'(1) << (W-1)) : ((QW'(1) << (W-1)) - 1'b1);
    qs   = (q > lim) ? lim : q;
  end

  always_ff @(posedge clk) begin
    p_r <= neg_r ? -$signed(qs[W-1:0]) : $signed(qs[W-1:0]);
  end

  assign p = p_r;

endmodule

FILE: src/jet_engine.sv
// Iteration engine: runs z = z*z + c on one queued pixel at a time through
// the shared product unit and holds the result word. Depends on jet_pkg,
// jet_res_if and jet_mul.
`include "assert_macros.svh"

module jet_engine #(
  parameter int MAX_ITER = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  jet_pkg::jet_cfg_t   cfg,
  input  jet_pkg::jet_q_stat_t qs,
  input  jet_pkg::jet_item_t  item,
  output logic                pop,
  jet_res_if.source           out_res
);
  import jet_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [2:0] PH_ISSUE_SUM = 3'd0;
  localparam logic [2:0] PH_ISSUE_XY  = 3'd1;
  localparam logic [2:0] PH_TAKE_RE   = 3'd2;
  localparam logic [2:0] PH_TAKE_IM   = 3'd3;
  localparam logic [2:0] PH_ISSUE_YY  = 3'd4;
  localparam logic [2:0] PH_TAKE_XX   = 3'd5;
  localparam logic [2:0] PH_CHECK     = 3'd6;

  logic [1:0]           state_r;
  logic [1:0]           state_nxt;
  logic [2:0]           ph_r;
  logic [2:0]           ph_nxt;
  logic signed [W-1:0]  x_r;
  logic signed [W-1:0]  y_r;
  logic signed [W-1:0]  xx_r;
  logic [CNT_W-1:0]     k_r;
  logic [CNT_W-1:0]     k_inc;
  logic [CNT_W-1:0]     lim;
  logic [CNT_W-1:0]     lim_r;
  logic                 esc_r;
  logic [PIX_W-1:0]     col_r;
  logic [PIX_W-1:0]     row_r;
  logic signed [OP_W-1:0] op_a;
  logic signed [OP_W-1:0] op_b;
  logic signed [W-1:0]  prod;
  logic [W:0]           r2;
  logic [W:0]           bound;
  logic                 hit;
  logic                 stop;
  logic                 ld;
  logic                 out_valid_r;
  logic [PIX_W-1:0]     out_col_r;
  logic [PIX_W-1:0]     out_row_r;
  logic [CNT_W-1:0]     out_cnt_r;
  logic                 out_esc_r;

  jet_mul u_mul (
    .clk (clk),
    .a   (op_a),
    .b   (op_b),
    .p   (prod)
  );

  assign lim = (32'(cfg.iter_limit) > MAX_ITER - 1) ? CNT_W'(MAX_ITER - 1)
                                                    : CNT_W'(cfg.iter_limit);
  assign bound = {5'd0, 16'(16'(cfg.esc_radius) * 16'(cfg.esc_radius)), 28'd0};

  // Both squares are non-negative, so their sum needs one extra bit only.
  assign r2    = {1'b0, prod} + {1'b0, xx_r};
  assign k_inc = k_r + 1'b1;
  assign hit   = (r2 >= bound);
  assign stop  = hit || (k_inc > lim_r);

  assign pop = (state_r == ST_IDLE) && !qs.empty;
  assign ld  = (state_r == ST_DONE) && (!out_valid_r || out_res.ready);

  // Operand select for the product issued in each phase.
  always_comb begin
    unique case (ph_r)
      PH_ISSUE_SUM: begin
        op_a = {x_r[W-1], x_r} + {y_r[W-1], y_r};
        op_b = {x_r[W-1], x_r} - {y_r[W-1], y_r};
      end
      PH_ISSUE_XY: begin
        op_a = {x_r[W-1], x_r};
        op_b = {y_r[W-1], y_r};
      end
      PH_TAKE_IM: begin
        op_a = {x_r[W-1], x_r};
        op_b = {x_r[W-1], x_r};
      end
      PH_ISSUE_YY: begin
        op_a = {y_r[W-1], y_r};
        op_b = {y_r[W-1], y_r};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop) begin
          state_nxt = ST_RUN;
          ph_nxt    = PH_ISSUE_SUM;
        end
      end
      ST_RUN: begin
        if (ph_r == PH_CHECK) begin
          ph_nxt = PH_ISSUE_SUM;
          if (stop) begin
            state_nxt = ST_DONE;
          end
        end else begin
          ph_nxt = ph_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (ld) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        ph_nxt    = PH_ISSUE_SUM;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ph_r    <= PH_ISSUE_SUM;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      x_r   <= item.x0;
      y_r   <= item.y0;
      col_r <= item.col;
      row_r <= item.row;
      k_r   <= '0;
      lim_r <= lim;
    end else if (state_r == ST_RUN) begin
      case (ph_r)
        PH_TAKE_RE: x_r  <= sat_w({{2{prod[W-1]}}, prod} + {{(W-30){cfg.c_real[31]}}, cfg.c_real});
        PH_TAKE_IM: y_r  <= sat_w({prod[W-1], prod, 1'b0} + {{(W-30){cfg.c_imag[31]}}, cfg.c_imag});
        PH_TAKE_XX: xx_r <= prod;
        PH_CHECK: begin
          k_r   <= k_inc;
          esc_r <= hit;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_col_r <= col_r;
      out_row_r <= row_r;
      out_cnt_r <= k_r;
      out_esc_r <= esc_r;
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.out_col    = out_col_r;
  assign out_res.out_row    = out_row_r;
  assign out_res.iter_count = out_cnt_r;
  assign out_res.escaped    = out_esc_r;

  `ASSERT_IMP(a_count_in_range, clk, rst_n, state_r == ST_RUN, k_r <= lim_r, "iteration count passed the limit")
  `ASSERT_IMP(a_done_counted, clk, rst_n, state_r == ST_DONE, k_r != '0, "finished pixel has no iteration")
  `ASSERT_IMP(a_idle_phase, clk, rst_n, state_r != ST_RUN, ph_r == PH_ISSUE_SUM, "phase not rewound outside a run")
  `ASSERT_NXT(a_load_shows, clk, rst_n, ld, out_valid_r && (state_r == ST_IDLE), "result word not presented")

endmodule

FILE: src/julia_escape_time_core.sv
// Top level of the Julia escape-time block: configuration registers, front
// end, pixel queue and iteration engine. Depends on jet_pkg and jet_if.
//
// Each pixel (column, row) is mapped to z0 = x_origin + col*x_step +
// i*(y_origin + row*y_step), then z = z*z + c is iterated in Q20.28 with
// saturation until |z|^2 reaches escape_radius^2 or the count passes the
// iteration limit; one result word carries the echoed column and row, the
// iteration count and the escaped flag. One pixel is iterated at a time: the
// four products of an iteration go one after another through a single
// two-stage product unit, and the iteration limit resets to 250. A two-word
// queue in front of the engine keeps pixels coming in while one is iterating,
// and the result register lets the engine start the next pixel while a result
// waits to be taken. Configuration writes are always ready and take effect on
// the next cycle; write them only while no pixel is in flight.
module julia_escape_time_core #(
  parameter int MAX_DIM  = 4096,
  parameter int MAX_ITER = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  jet_pix_if.sink    in_pix,
  jet_res_if.source  out_res,
  jet_cfg_if.sink    cfg_wr
);
  import jet_pkg::*;

  jet_cfg_t    cfg_r;
  jet_item_t   push_item;
  jet_item_t   pop_item;
  jet_q_stat_t qs;
  logic        push;
  logic        pop;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.c_real     <= '0;
      cfg_r.c_imag     <= '0;
      cfg_r.x_origin   <= RST_ORIGIN;
      cfg_r.y_origin   <= RST_ORIGIN;
      cfg_r.x_step     <= RST_STEP;
      cfg_r.y_step     <= RST_STEP;
      cfg_r.iter_limit <= RST_LIMIT;
      cfg_r.esc_radius <= RST_RADIUS;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.reg_index)
        REG_C_REAL:   cfg_r.c_real     <= cfg_wr.wdata;
        REG_C_IMAG:   cfg_r.c_imag     <= cfg_wr.wdata;
        REG_X_ORIGIN: cfg_r.x_origin   <= cfg_wr.wdata;
        REG_Y_ORIGIN: cfg_r.y_origin   <= cfg_wr.wdata;
        REG_X_STEP:   cfg_r.x_step     <= cfg_wr.wdata[30:0];
        REG_Y_STEP:   cfg_r.y_step     <= cfg_wr.wdata[30:0];
        REG_ITER_LIM: cfg_r.iter_limit <= cfg_wr.wdata[9:0];
        REG_RADIUS:   cfg_r.esc_radius <= cfg_wr.wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  jet_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .in_pix (in_pix),
    .cfg    (cfg_r),
    .qs     (qs),
    .push   (push),
    .item   (push_item)
  );

  jet_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .qs        (qs)
  );

  jet_engine #(
    .MAX_ITER (MAX_ITER)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .qs      (qs),
    .item    (pop_item),
    .pop     (pop),
    .out_res (out_res)
  );

endmodule
